[hdl/ibc_pkg.sv]
// shared types, constants and helpers for the imu bias calibrate and correct block
`default_nettype none

package ibc_pkg;

    // data and configuration widths
    localparam int DATA_W          = 32;
    localparam int CFG_W           = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int NUM_AXES        = 6;
    localparam int AXIS_W          = 3;

    localparam logic [CFG_W-1:0] SAMPLE_COUNT_RST = 16'd1000;

    // scale factors: gravity * 2^24 and (pi / 180.0) * 2^32
    localparam int K_W    = 29;
    localparam int PROD_W = DATA_W + 1 + K_W;
    localparam logic signed [K_W-1:0] ACC_K = 29'sd164528285;
    localparam logic signed [K_W-1:0] GYR_K = 29'sd74961321;
    localparam int ACC_F = 24;
    localparam int GYR_F = 32;

    // gravity in q16.16
    localparam logic signed [DATA_W-1:0] G_Q16 = 32'sd642689;

    // opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_START  = 1'b1;

    // axis codes
    typedef logic [AXIS_W-1:0] axis_t;
    localparam axis_t AX_ACC_X = 3'd0;
    localparam axis_t AX_ACC_Y = 3'd1;
    localparam axis_t AX_ACC_Z = 3'd2;
    localparam axis_t AX_GYR_X = 3'd3;
    localparam axis_t AX_GYR_Y = 3'd4;
    localparam axis_t AX_GYR_Z = 3'd5;
    localparam axis_t AX_NONE  = 3'd6;

    // input transfer
    typedef struct packed {
        logic                     opcode;
        logic signed [DATA_W-1:0] accel_x_in;
        logic signed [DATA_W-1:0] accel_y_in;
        logic signed [DATA_W-1:0] accel_z_in;
        logic signed [DATA_W-1:0] gyro_x_in;
        logic signed [DATA_W-1:0] gyro_y_in;
        logic signed [DATA_W-1:0] gyro_z_in;
    } imu_in_t;

    // output transfer
    typedef struct packed {
        logic signed [DATA_W-1:0] accel_x_out;
        logic signed [DATA_W-1:0] accel_y_out;
        logic signed [DATA_W-1:0] accel_z_out;
        logic signed [DATA_W-1:0] gyro_x_out;
        logic signed [DATA_W-1:0] gyro_y_out;
        logic signed [DATA_W-1:0] gyro_z_out;
        logic                     calibrating;
    } imu_out_t;

    // tag travelling with each axis through the scaler
    typedef struct packed {
        logic  valid;
        axis_t axis;
    } scl_tag_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_CORR,
        ST_OUT
    } ibc_state_t;

    // clamp a wide signed value to 32-bit signed
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/ibc_scaler.sv]
// three-stage unit: axis sign flip, constant multiply, round and saturate
`default_nettype none

module ibc_scaler (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ibc_pkg::scl_tag_t                tag_in,
    input  logic signed [ibc_pkg::DATA_W-1:0] raw,
    output ibc_pkg::scl_tag_t                tag_out,
    output logic signed [ibc_pkg::DATA_W-1:0] value
);
    import ibc_pkg::*;

    localparam logic signed [PROD_W-1:0] ACC_HALF = PROD_W'(1) << (ACC_F - 1);
    localparam logic signed [PROD_W-1:0] GYR_HALF = PROD_W'(1) << (GYR_F - 1);

    scl_tag_t                  tag1_reg, tag2_reg, tag3_reg;
    logic signed [DATA_W:0]    s1_reg;
    logic signed [K_W-1:0]     k1_reg;
    logic                      gyro1_reg, gyro2_reg;
    logic signed [PROD_W-1:0]  p2_reg;
    logic signed [DATA_W-1:0]  value_reg;

    logic                      negate;
    logic                      is_gyro;
    logic signed [DATA_W:0]    s_ext;
    logic signed [PROD_W-1:0]  rounded;
    logic signed [PROD_W-1:0]  shifted;

    // x and z axes are mirrored, gyro axes take the angle scale
    always_comb
    begin
        negate  = (tag_in.axis == AX_ACC_X) || (tag_in.axis == AX_ACC_Z) ||
                  (tag_in.axis == AX_GYR_X) || (tag_in.axis == AX_GYR_Z);
        is_gyro = (tag_in.axis >= AX_GYR_X);
        s_ext   = {raw[DATA_W-1], raw};
    end

    // round half up and drop the fraction
    always_comb
    begin
        rounded = p2_reg + (gyro2_reg ? GYR_HALF : ACC_HALF);
        shifted = gyro2_reg ? (rounded >>> GYR_F) : (rounded >>> ACC_F);
    end

    // tag pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        s1_reg    <= negate ? -s_ext : s_ext;
        k1_reg    <= is_gyro ? GYR_K : ACC_K;
        gyro1_reg <= is_gyro;
        p2_reg    <= PROD_W'(s1_reg) * PROD_W'(k1_reg);
        gyro2_reg <= gyro1_reg;
        value_reg <= sat32(64'(shifted));
    end

    assign tag_out = tag3_reg;
    assign value   = value_reg;

endmodule

`default_nettype wire

[hdl/ibc_divider.sv]
// restoring divider, one quotient bit per cycle, signed dividend truncated toward zero
`default_nettype none

module ibc_divider #(
    parameter int SUM_W = 48,
    parameter int DIV_W = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [SUM_W-1:0]           dividend,
    input  logic [DIV_W-1:0]                  divisor,
    output logic                              done,
    output logic signed [ibc_pkg::DATA_W-1:0] quotient
);
    import ibc_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic                      busy_reg;
    logic                      done_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [SUM_W-1:0]          quo_reg;
    logic [DIV_W-1:0]          rem_reg;
    logic [DIV_W-1:0]          den_reg;
    logic                      neg_reg;
    logic signed [DATA_W-1:0]  q_out_reg;

    logic [SUM_W-1:0]          magnitude;
    logic [DIV_W:0]            shifted;
    logic                      fits;
    logic [DIV_W:0]            diff;
    logic [DIV_W-1:0]          rem_next;
    logic [SUM_W-1:0]          quo_next;
    logic [SUM_W-1:0]          signed_quo;

    // one restoring step
    always_comb
    begin
        magnitude  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
        shifted    = {rem_reg, quo_reg[SUM_W-1]};
        fits       = (shifted >= {1'b0, den_reg});
        diff       = shifted - {1'b0, den_reg};
        rem_next   = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
        quo_next   = {quo_reg[SUM_W-2:0], fits};
        signed_quo = neg_reg ? -quo_next : quo_next;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= magnitude;
            rem_reg <= '0;
            den_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            if (step_reg == STEP_W'(1))
            begin
                q_out_reg <= signed_quo[DATA_W-1:0];
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_out_reg;

endmodule

`default_nettype wire

[hdl/imu_bias_calibrate_correct.sv]
// Flow: a sample is accepted in idle, its axes are scaled and corrected, and the
// result is registered for output; the sample that ends a calibration also runs
// each axis through the shared bit-serial divider. A start command is accepted in
// idle and gives no result. The single shared scaler multiplier and correction
// subtractor serve one axis at a time; the input stalls while an item is in work.
// Reset: rst_n clears the state, sums, biases and sets sample_count to 1000.
`default_nettype none

module imu_bias_calibrate_correct #(
    parameter int COUNT_WIDTH = ibc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  ibc_pkg::imu_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output ibc_pkg::imu_out_t               out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ibc_pkg::CFG_W-1:0]       cfg_data
);
    import ibc_pkg::*;

    localparam int SUM_W = DATA_W + COUNT_WIDTH;
    localparam int TGT_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
    localparam logic [TGT_W-1:0] CNT_MAX = TGT_W'({COUNT_WIDTH{1'b1}});
    localparam axis_t AX_LAST = AX_GYR_Z;

    ibc_state_t                state_reg, state_next;
    logic [CFG_W-1:0]          sample_count_reg;
    logic                      calib_active_reg;
    logic [COUNT_WIDTH-1:0]    collected_reg;
    logic                      accum_reg;
    logic                      finish_reg;
    axis_t                     issue_cnt_reg;
    axis_t                     axis_cnt_reg;
    logic signed [SUM_W-1:0]   sums_reg [NUM_AXES];
    logic signed [DATA_W-1:0]  bias_reg [NUM_AXES];
    logic signed [DATA_W-1:0]  conv_reg [NUM_AXES];
    imu_in_t                   sample_reg;
    logic                      out_valid_reg;
    imu_out_t                  out_data_reg;

    logic                      accept;
    logic                      is_start;
    logic                      out_free;
    logic [TGT_W-1:0]          target;
    logic                      below_target;
    scl_tag_t                  scl_in;
    scl_tag_t                  scl_out;
    logic signed [DATA_W-1:0]  scl_raw;
    logic signed [DATA_W-1:0]  scl_value;
    logic                      div_start;
    logic                      div_done;
    logic signed [DATA_W-1:0]  div_q;
    axis_t                     sum_idx;
    logic signed [SUM_W-1:0]   sum_rd;
    logic signed [DATA_W:0]    z_adj;
    logic signed [DATA_W-1:0]  bias_wr;
    logic signed [DATA_W-1:0]  corr_wr;

    // handshakes
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign is_start  = (in_data.opcode == OP_START);
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // calibration target, clamped to the counter range
    always_comb
    begin
        target       = (TGT_W'(sample_count_reg) < CNT_MAX) ? TGT_W'(sample_count_reg)
                                                            : CNT_MAX;
        below_target = (TGT_W'(collected_reg) < target);
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        scl_in.valid = 1'b0;
        scl_in.axis  = issue_cnt_reg;
        div_start    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !is_start)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                scl_in.valid = (issue_cnt_reg <= AX_LAST);
                if (scl_out.valid && scl_out.axis == AX_LAST)
                begin
                    state_next = finish_reg ? ST_DIV_START : ST_CORR;
                end
            end
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (axis_cnt_reg == AX_LAST) ? ST_CORR : ST_DIV_START;
                end
            end
            ST_CORR:
            begin
                if (axis_cnt_reg == AX_LAST)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // raw axis feeding the scaler
    always_comb
    begin
        case (issue_cnt_reg)
            AX_ACC_X: scl_raw = sample_reg.accel_x_in;
            AX_ACC_Y: scl_raw = sample_reg.accel_y_in;
            AX_ACC_Z: scl_raw = sample_reg.accel_z_in;
            AX_GYR_X: scl_raw = sample_reg.gyro_x_in;
            AX_GYR_Y: scl_raw = sample_reg.gyro_y_in;
            default:  scl_raw = sample_reg.gyro_z_in;
        endcase
    end

    // single read port on the sums
    assign sum_idx = (state_reg == ST_SCALE) ? scl_out.axis : axis_cnt_reg;
    assign sum_rd  = sums_reg[sum_idx];

    // new bias; accel z loses gravity towards zero
    always_comb
    begin
        z_adj = {div_q[DATA_W-1], div_q};
        if (div_q[DATA_W-1])
        begin
            z_adj = z_adj + (DATA_W+1)'(G_Q16);
        end
        else if (div_q != '0)
        begin
            z_adj = z_adj - (DATA_W+1)'(G_Q16);
        end
        if (collected_reg == '0)
        begin
            bias_wr = '0;
        end
        else if (axis_cnt_reg == AX_ACC_Z)
        begin
            bias_wr = sat32(64'(z_adj));
        end
        else
        begin
            bias_wr = div_q;
        end
        corr_wr = sat32(64'(conv_reg[axis_cnt_reg]) - 64'(bias_reg[axis_cnt_reg]));
    end

    // shared scaler
    ibc_scaler u_scaler (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (scl_in),
        .raw     (scl_raw),
        .tag_out (scl_out),
        .value   (scl_value)
    );

    // shared divider
    ibc_divider #(
        .SUM_W (SUM_W),
        .DIV_W (COUNT_WIDTH)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_rd),
        .divisor  (collected_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= SAMPLE_COUNT_RST;
            calib_active_reg <= 1'b0;
            collected_reg    <= '0;
            accum_reg        <= 1'b0;
            finish_reg       <= 1'b0;
            issue_cnt_reg    <= '0;
            axis_cnt_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                sample_count_reg <= cfg_data;
            end
            if (accept)
            begin
                issue_cnt_reg <= '0;
                axis_cnt_reg  <= '0;
                if (is_start)
                begin
                    calib_active_reg <= 1'b1;
                    collected_reg    <= '0;
                end
                else
                begin
                    accum_reg  <= calib_active_reg && below_target;
                    finish_reg <= calib_active_reg && !below_target;
                    if (calib_active_reg && below_target)
                    begin
                        collected_reg <= collected_reg + 1'b1;
                    end
                    else if (calib_active_reg)
                    begin
                        calib_active_reg <= 1'b0;
                    end
                end
            end
            if (scl_in.valid)
            begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
            end
            if ((state_reg == ST_DIV_WAIT && div_done) || state_reg == ST_CORR)
            begin
                axis_cnt_reg <= (axis_cnt_reg == AX_LAST) ? '0 : axis_cnt_reg + 1'b1;
            end
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // sums and biases
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                sums_reg[i] <= '0;
                bias_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept && is_start)
            begin
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    sums_reg[i] <= '0;
                end
            end
            if (state_reg == ST_SCALE && scl_out.valid && accum_reg)
            begin
                sums_reg[scl_out.axis] <= sum_rd + SUM_W'(scl_value);
            end
            if (state_reg == ST_DIV_WAIT && div_done)
            begin
                bias_reg[axis_cnt_reg] <= bias_wr;
            end
        end
    end

    // sample, converted axes and output payload
    always_ff @(posedge clk)
    begin
        if (accept && !is_start)
        begin
            sample_reg <= in_data;
        end
        if (state_reg == ST_SCALE && scl_out.valid)
        begin
            conv_reg[scl_out.axis] <= scl_value;
        end
        if (state_reg == ST_CORR)
        begin
            conv_reg[axis_cnt_reg] <= corr_wr;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_data_reg.accel_x_out <= conv_reg[AX_ACC_X];
            out_data_reg.accel_y_out <= conv_reg[AX_ACC_Y];
            out_data_reg.accel_z_out <= conv_reg[AX_ACC_Z];
            out_data_reg.gyro_x_out  <= conv_reg[AX_GYR_X];
            out_data_reg.gyro_y_out  <= conv_reg[AX_GYR_Y];
            out_data_reg.gyro_z_out  <= conv_reg[AX_GYR_Z];
            out_data_reg.calibrating <= calib_active_reg;
        end
    end

endmodule

`default_nettype wire

[hdl/ibc_checker.sv]
// port-level checks for the imu bias calibrate and correct block, bound to the top level
`default_nettype none

module ibc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input ibc_pkg::imu_in_t   in_data,
    input logic               out_valid,
    input logic               out_stall,
    input ibc_pkg::imu_out_t  out_data
);
    import ibc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // a sample keeps the block busy in the following cycle
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.opcode == OP_SAMPLE |=> in_stall)
        else $error("input not stalled after sample transfer");

    // a start command produces no result
    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.opcode == OP_START && !out_valid |=> !out_valid)
        else $error("result appeared after start command");

    // a result only appears while a sample is in work
    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no sample in work");

endmodule

bind imu_bias_calibrate_correct ibc_checker u_ibc_checker (.*);

`default_nettype wire
